FILE: hdl/ymodem_receiver_top_macros.svh
// assertion macros for the ymodem receiver
`ifndef YMODEM_RECEIVER_TOP_MACROS_SVH
`define YMODEM_RECEIVER_TOP_MACROS_SVH
// implication checked at every clock edge outside reset
`define YMR_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication whose consequent is checked in the following cycle
`define YMR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hdl/ymr_pkg.sv
// ----------------------------------------------------------------------------
// ymr_pkg
// types, constants and helpers shared by the ymodem receiver
// ----------------------------------------------------------------------------
package ymr_pkg;
  localparam int unsigned ShortPayload = 128;
  localparam int unsigned LongPayload  = 1024;
  localparam int unsigned MaxResults   = 3;

  localparam logic [7:0] ChSoh = 8'h01;
  localparam logic [7:0] ChStx = 8'h02;
  localparam logic [7:0] ChEot = 8'h04;
  localparam logic [7:0] ChAck = 8'h06;
  localparam logic [7:0] ChNak = 8'h15;
  localparam logic [7:0] ChC   = 8'h43;

  localparam logic [31:0] InitTimeoutRst = 32'd10000;
  localparam logic [31:0] RecvTimeoutRst = 32'd3000;

  typedef enum logic [1:0] {
    OpStart = 2'd0, OpByte = 2'd1, OpPoll = 2'd2, OpTick = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    EvNone = 3'd0, EvPayload = 3'd1, EvHeader = 3'd2, EvBlock = 3'd3,
    EvEnd = 3'd4, EvError = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    CfgInitTimeout = 2'd0, CfgRecvTimeout = 2'd1, CfgAllowLong = 2'd2
  } cfg_idx_e;

  typedef enum logic [4:0] {
    PhStop = 5'b00001, PhInit = 5'b00010, PhHeader = 5'b00100,
    PhData = 5'b01000, PhEnd = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [2:0]  event_res;
    logic [7:0]  payload_byte;
    logic [7:0]  block_number;
    logic [10:0] block_length;
    logic [31:0] size_bytes;
    logic [1:0]  error_stage;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  count;
    out_item_t   r0;
    out_item_t   r1;
    out_item_t   r2;
  } result_set_t;

  typedef struct packed {
    logic [31:0] init_timeout;
    logic [31:0] recv_timeout;
    logic        allow_long;
  } cfg_t;

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

  function automatic out_item_t mk(logic txv, logic [7:0] txb, event_e ev);
    out_item_t r;
    r = '0;
    r.tx_valid = txv;
    r.tx_byte = txv ? txb : 8'h00;
    r.event_res = ev;
    return r;
  endfunction
endpackage

FILE: hdl/ymr_core.sv
// ----------------------------------------------------------------------------
// ymr_core
// protocol state and per-item result set, one item per enable
// ----------------------------------------------------------------------------
module ymr_core
  import ymr_pkg::*;
#(
  parameter int unsigned SHORT_LEN = ShortPayload,
  parameter int unsigned LONG_LEN  = LongPayload
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  in_item_t    item_i,
  input  cfg_t        cfg_i,
  output result_set_t res_o
);
  localparam logic [10:0] ShortL = 11'(SHORT_LEN);
  localparam logic [10:0] LongL  = 11'(LONG_LEN);

  phase_e      phase_q, phase_d;
  logic [10:0] pos_q, pos_d;
  logic        long_q, long_d;
  logic [7:0]  exp_q, exp_d, seq_q, seq_d;
  logic        cok_q, cok_d;
  logic [15:0] crc_q, crc_d, rcrc_q, rcrc_d;
  logic [31:0] el_q, el_d;
  logic        ne_q, ne_d, dd_q, dd_d;
  logic [31:0] sz_q, sz_d;

  always_comb begin
    logic [7:0]  b;
    logic [10:0] len;
    logic        done, good;
    logic [7:0]  want, nxt;
    logic [35:0] v;
    logic [31:0] lim, el1;
    out_item_t   rs [3];
    int unsigned n;
    b = item_i.rx_byte;
    phase_d = phase_q; pos_d = pos_q; long_d = long_q; exp_d = exp_q;
    seq_d = seq_q; cok_d = cok_q; crc_d = crc_q; rcrc_d = rcrc_q;
    el_d = el_q; ne_d = ne_q; dd_d = dd_q; sz_d = sz_q;
    rs[0] = '0; rs[1] = '0; rs[2] = '0; n = 0;
    done = 1'b0;
    good = 1'b0;
    len = long_q ? LongL : ShortL;
    nxt = exp_q + 8'd1;
    want = (phase_q == PhData) ? nxt : 8'd0;
    v = '0;
    lim = (phase_q == PhInit) ? cfg_i.init_timeout : cfg_i.recv_timeout;
    el1 = (el_q == '1) ? el_q : el_q + 32'd1;
    unique case (op_e'(item_i.operation))
      OpStart: begin
        if (phase_q == PhStop) begin
          phase_d = PhInit; pos_d = '0; long_d = 1'b0; exp_d = '0; seq_d = '0;
          cok_d = 1'b0; crc_d = '0; rcrc_d = '0; el_d = '0; ne_d = 1'b0;
          dd_d = 1'b0; sz_d = '0;
        end
      end
      OpTick: begin
        if (phase_q != PhStop) begin
          el_d = el1;
          if (el1 >= lim) begin
            rs[0] = mk(1'b0, 8'h00, EvError);
            unique case (phase_q)
              PhInit:   rs[0].error_stage = 2'd0;
              PhHeader: rs[0].error_stage = 2'd1;
              PhData:   rs[0].error_stage = 2'd2;
              default:  rs[0].error_stage = 2'd3;
            endcase
            n = 1;
            phase_d = PhStop; pos_d = '0; long_d = 1'b0; exp_d = '0; seq_d = '0;
            cok_d = 1'b0; crc_d = '0; rcrc_d = '0; el_d = '0; ne_d = 1'b0;
            dd_d = 1'b0; sz_d = '0;
          end
        end
      end
      OpPoll: begin
        if (phase_q == PhInit) begin
          rs[0] = mk(1'b1, ChC, EvNone); n = 1;
        end
      end
      default: begin
        if (phase_q == PhInit) begin
          if (b == ChSoh) begin
            phase_d = PhHeader; el_d = '0; long_d = 1'b0; pos_d = 11'd1;
            seq_d = '0; cok_d = 1'b0; crc_d = '0; rcrc_d = '0;
            ne_d = 1'b0; sz_d = '0; dd_d = 1'b0;
          end else begin
            rs[0] = mk(1'b1, ChC, EvNone); n = 1;
          end
        end else if (phase_q != PhStop) begin
          if (pos_q == '0) begin
            if (b == ChSoh || (phase_q == PhData && b == ChStx && cfg_i.allow_long)) begin
              long_d = (b == ChStx); pos_d = 11'd1;
              seq_d = '0; cok_d = 1'b0; crc_d = '0; rcrc_d = '0;
              ne_d = 1'b0; sz_d = '0; dd_d = 1'b0;
            end else if (b == ChEot && phase_q == PhData) begin
              phase_d = PhEnd; el_d = '0;
              rs[0] = mk(1'b1, ChNak, EvNone); n = 1;
            end else if (b == ChEot && phase_q == PhEnd) begin
              rs[0] = mk(1'b1, ChAck, EvNone); rs[1] = mk(1'b1, ChC, EvNone); n = 2;
            end
          end else begin
            if (pos_q <= 11'd1) begin
              seq_d = b;
            end else if (pos_q == 11'd2) begin
              cok_d = ((seq_q ^ b) == 8'hFF);
            end else if (pos_q < len + 11'd3) begin
              crc_d = crc16_byte(crc_q, b);
              if (phase_q == PhHeader) begin
                if (!ne_q) begin
                  if (b == 8'h00) ne_d = 1'b1;
                end else if (!dd_q) begin
                  if (b >= 8'h30 && b <= 8'h39) begin
                    // size times ten plus the digit
                    v = ({4'h0, sz_q} << 3) + ({4'h0, sz_q} << 1) + {28'h0, b - 8'h30};
                    sz_d = (v > 36'hFFFFFFFF) ? '1 : v[31:0];
                  end else begin
                    dd_d = 1'b1;
                  end
                end
              end
              rs[0] = mk(1'b0, 8'h00, EvPayload); rs[0].payload_byte = b; n = 1;
            end else if (pos_q == len + 11'd3) begin
              rcrc_d = {b, 8'h00};
            end else begin
              rcrc_d = {rcrc_q[15:8], b};
              done = 1'b1;
            end
            pos_d = done ? 11'd0 : pos_q + 11'd1;
            good = done && (seq_q == want) && cok_q && (crc_q == {rcrc_q[15:8], b});
            if (good) begin
              unique case (phase_q)
                PhHeader: begin
                  phase_d = PhData; exp_d = '0; el_d = '0;
                  rs[0] = mk(1'b1, ChAck, EvHeader); rs[0].block_length = ShortL;
                  rs[0].size_bytes = ne_q ? sz_q : 32'd0;
                  rs[1] = mk(1'b1, ChC, EvNone); n = 2;
                end
                PhData: begin
                  exp_d = nxt; el_d = '0;
                  rs[0] = mk(1'b1, ChAck, EvBlock); rs[0].block_number = nxt;
                  rs[0].block_length = len; n = 1;
                end
                default: begin
                  phase_d = PhStop; pos_d = '0; long_d = 1'b0; exp_d = '0;
                  seq_d = '0; cok_d = 1'b0; crc_d = '0; rcrc_d = '0; el_d = '0;
                  ne_d = 1'b0; dd_d = 1'b0; sz_d = '0;
                  rs[0] = mk(1'b1, ChAck, EvEnd); rs[0].block_length = ShortL; n = 1;
                end
              endcase
            end
          end
        end
      end
    endcase
    if (n == 1) rs[0].last = 1'b1;
    if (n == 2) rs[1].last = 1'b1;
    res_o.count = 2'(n);
    res_o.r0 = rs[0]; res_o.r1 = rs[1]; res_o.r2 = rs[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStop; pos_q <= '0; long_q <= 1'b0; exp_q <= '0; seq_q <= '0;
      cok_q <= 1'b0; crc_q <= '0; rcrc_q <= '0; el_q <= '0; ne_q <= 1'b0;
      dd_q <= 1'b0; sz_q <= '0;
    end else if (en_i) begin
      phase_q <= phase_d; pos_q <= pos_d; long_q <= long_d; exp_q <= exp_d;
      seq_q <= seq_d; cok_q <= cok_d; crc_q <= crc_d; rcrc_q <= rcrc_d;
      el_q <= el_d; ne_q <= ne_d; dd_q <= dd_d; sz_q <= sz_d;
    end
  end
endmodule

FILE: hdl/ymr_outq.sv
// ----------------------------------------------------------------------------
// ymr_outq
// result queue, takes up to three results per cycle, gives one per request
// ----------------------------------------------------------------------------
module ymr_outq
  import ymr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  result_set_t set_i,
  output logic        room_o,
  output logic        valid_o,
  input  logic        stall_i,
  output out_item_t   data_o
);
  localparam int unsigned Depth = 4;
  out_item_t   mem_q [Depth];
  logic [1:0]  rd_q, wr_q;
  logic [2:0]  cnt_q;
  logic        pop;
  logic [2:0]  add;

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign pop     = valid_o && !stall_i;
  assign add     = push_i ? {1'b0, set_i.count} : 3'd0;
  // room for a worst case set even when nothing is popped this cycle
  assign room_o  = (cnt_q <= 3'(Depth - MaxResults));

  always_ff @(posedge clk_i) begin
    if (add > 3'd0) mem_q[wr_q] <= set_i.r0;
    if (add > 3'd1) mem_q[wr_q + 2'd1] <= set_i.r1;
    if (add > 3'd2) mem_q[wr_q + 2'd2] <= set_i.r2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0; wr_q <= '0; cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + add[1:0];
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_q + add - {2'b00, pop};
    end
  end
endmodule

FILE: hdl/ymodem_receiver_top.sv
// ----------------------------------------------------------------------------
// ymodem_receiver_top
// ymodem crc-16 receiver with 1k frames, while not stalled one request per cycle
// ----------------------------------------------------------------------------
// channel  direction  handshake        payload
// in       input      in_valid/stall   in_item_t (operation, rx_byte)
// out      output     out_valid/stall  out_item_t (one result)
// cfg      input      valid/ready      register index, 32-bit data
//
// while not stalled, one request is taken every cycle; its results land in a four-entry queue
// set by the state update path (crc byte step and size digit multiply)
// input stalls while the queue could not hold three more results
// async active-low reset: phase stop, timeouts 10000/3000, long frames on
// ----------------------------------------------------------------------------
module ymodem_receiver_top
  import ymr_pkg::*;
#(
  parameter int unsigned SHORT_LEN = ShortPayload,
  parameter int unsigned LONG_LEN  = LongPayload
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  `include "ymodem_receiver_top_macros.svh"

  cfg_t        cfg_q;
  result_set_t set;
  logic        room, take;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !room;
  assign take        = in_valid_i && room;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_timeout <= InitTimeoutRst;
      cfg_q.recv_timeout <= RecvTimeoutRst;
      cfg_q.allow_long   <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgInitTimeout: cfg_q.init_timeout <= cfg_data_i;
        CfgRecvTimeout: cfg_q.recv_timeout <= cfg_data_i;
        CfgAllowLong:   cfg_q.allow_long   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  ymr_core #(.SHORT_LEN(SHORT_LEN), .LONG_LEN(LONG_LEN)) u_core (
    .clk_i, .rst_ni, .en_i(take), .item_i(in_data_i), .cfg_i(cfg_q), .res_o(set)
  );

  ymr_outq u_outq (
    .clk_i, .rst_ni, .push_i(take), .set_i(set), .room_o(room),
    .valid_o(out_valid_o), .stall_i(out_stall_i), .data_o(out_data_o)
  );

  `YMR_ASSERT(a_nak_no_event, out_valid_o && out_data_o.tx_byte == ChNak,
    out_data_o.event_res == EvNone)
  `YMR_ASSERT(a_tx_zero, out_valid_o && !out_data_o.tx_valid, out_data_o.tx_byte == 8'h00)
  `YMR_ASSERT_NEXT(a_hold, out_valid_o && out_stall_i, out_valid_o)
endmodule
